>>> sv/oaa_pkg.sv
// shared types, constants and helpers for the overlap-add accumulator
`timescale 1ns / 1ps
`default_nettype none

package oaa_pkg;

    localparam int FRAME_LEN_DEF = 512;
    localparam int CHANNELS_DEF  = 2;

    localparam int IDX_W   = 9;
    localparam int SMP_W   = 16;
    localparam int COEF_W  = 16;
    localparam int VAL_W   = 32;
    localparam int HOP_W   = 10;
    localparam int CFG_W   = 10;
    localparam int CFGI_W  = 1;
    localparam int IN_W    = 48;
    localparam int FUNC_W  = 2;

    localparam int HOP_RESET = 512;

    localparam logic [CFGI_W-1:0] CFG_ENABLE = 1'b0;
    localparam logic [CFGI_W-1:0] CFG_HOP    = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_ACC   = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_CLEAR = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_ACC_MUL,
        ST_ACC_ADD,
        ST_RD_FETCH,
        ST_RD_HOLD
    } t_state;

    typedef struct packed {
        logic load_coef;
        logic acc_start;
        logic rd_start;
        logic clear_start;
        logic sweep;
        logic mult;
        logic acc_write;
        logic rd_zero;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  enable;
        logic  primed;
        logic  sweep_last;
        logic  out_free;
    } t_stat;

    // remainder of a narrow value by a constant, one compare and subtract per bit
    function automatic logic [HOP_W-1:0] mod_small(input logic [HOP_W-1:0] v,
                                                   input int unsigned m);
        logic [HOP_W-1:0] r;
        r = v;
        for (int k = HOP_W - 1; k >= 0; k--) begin
            if ((m << k) < (1 << HOP_W)) begin
                if (r >= HOP_W'(m << k)) begin
                    r = r - HOP_W'(m << k);
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/oaa_ctrl.sv
// controller state machine for the overlap-add accumulator
`timescale 1ns / 1ps
`default_nettype none

module oaa_ctrl
    import oaa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_stat i_stat,
    output logic      o_in_ready,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_stat.func)
                        FUNC_LOAD: begin
                            o_cmd.load_coef = 1'b1;
                        end
                        FUNC_CLEAR: begin
                            o_cmd.clear_start = 1'b1;
                            n_state = ST_SWEEP;
                        end
                        FUNC_ACC: begin
                            if (i_stat.enable) begin
                                o_cmd.acc_start = 1'b1;
                                n_state = ST_ACC_MUL;
                            end
                        end
                        FUNC_READ: begin
                            if (i_stat.enable && i_stat.primed) begin
                                o_cmd.rd_start = 1'b1;
                                n_state = ST_RD_FETCH;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ACC_MUL: begin
                o_cmd.mult = 1'b1;
                n_state = ST_ACC_ADD;
            end
            ST_ACC_ADD: begin
                o_cmd.acc_write = 1'b1;
                n_state = ST_IDLE;
            end
            ST_RD_FETCH: begin
                o_cmd.rd_zero = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_RD_HOLD;
                end
            end
            ST_RD_HOLD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/oaa_datapath.sv
// datapath: window table, accumulator store, positions and output register
`timescale 1ns / 1ps
`default_nettype none

module oaa_datapath
    import oaa_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF,
    parameter int CHANNELS  = CHANNELS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_stat                  o_stat,
    input  wire logic [IN_W-1:0]   i_in_data,
    input  wire logic [FUNC_W-1:0] i_in_user,
    input  wire logic              i_in_last,
    input  wire logic              i_cfg_we,
    input  wire logic [CFGI_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [VAL_W-1:0]       o_out_data,
    output logic                   o_out_last
);

    localparam int RING  = 2 * FRAME_LEN;
    localparam int DEPTH = CHANNELS * RING;
    localparam int PW    = $clog2(RING);
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(FRAME_LEN);
    localparam logic [PW:0] RING_W = (PW + 1)'(RING);
    localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

    function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] a,
                                               input logic [PW-1:0] b);
        logic [PW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= RING_W) begin
            s = s - RING_W;
        end
        return s[PW-1:0];
    endfunction

    logic [VAL_W-1:0]         r_store [DEPTH];
    logic [COEF_W-1:0]        r_table [FRAME_LEN];

    logic                     r_enable;
    logic [PW-1:0]            r_hop;
    logic [PW-1:0]            r_wpos;
    logic [PW-1:0]            r_rpos;
    logic                     r_primed;
    logic [AW-1:0]            r_sweep;
    logic [AW-1:0]            r_addr;
    logic signed [SMP_W-1:0]  r_sample;
    logic                     r_last;
    logic [VAL_W-1:0]         r_store_q;
    logic [COEF_W-1:0]        r_coef_q;
    logic signed [SMP_W+COEF_W:0] r_prod;
    logic                     r_out_valid;
    logic [VAL_W-1:0]         r_out_value;
    logic                     r_out_last;

    logic                     w_ch;
    logic [IDX_W-1:0]         w_idx;
    logic [SMP_W-1:0]         w_sample;
    logic [COEF_W-1:0]        w_coef;
    logic [PW-1:0]            w_off;
    logic [TW-1:0]            w_tidx;
    logic [PW-1:0]            w_pos;
    logic [AW-1:0]            w_base;
    logic [AW-1:0]            w_raddr;
    logic signed [SMP_W+COEF_W:0] w_shift;
    logic signed [VAL_W:0]    w_sum;
    logic [VAL_W-1:0]         w_sat;
    logic                     w_we;
    logic [AW-1:0]            w_wa;
    logic [VAL_W-1:0]         w_wd;

    assign w_ch     = (CHANNELS > 1) ? i_in_data[0] : 1'b0;
    assign w_idx    = i_in_data[IDX_W:1];
    assign w_sample = i_in_data[IDX_W+SMP_W:IDX_W+1];
    assign w_coef   = i_in_data[IDX_W+SMP_W+COEF_W:IDX_W+SMP_W+1];
    assign w_off    = PW'(mod_small({1'b0, w_idx}, RING));
    assign w_tidx   = TW'(mod_small({1'b0, w_idx}, FRAME_LEN));
    assign w_pos    = ring_add(i_cmd.acc_start ? r_wpos : r_rpos, w_off);
    assign w_base   = w_ch ? AW'(RING) : '0;
    assign w_raddr  = w_base + AW'(w_pos);

    // floor shift of the product, then saturating add
    assign w_shift = r_prod >>> 15;
    assign w_sum   = $signed({r_store_q[VAL_W-1], r_store_q}) + w_shift;
    always_comb begin
        if (w_sum[VAL_W] != w_sum[VAL_W-1]) begin
            w_sat = w_sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            w_sat = w_sum[VAL_W-1:0];
        end
    end

    always_comb begin
        w_we = 1'b0;
        w_wa = r_addr;
        w_wd = '0;
        if (i_cmd.sweep) begin
            w_we = 1'b1;
            w_wa = r_sweep;
        end else if (i_cmd.acc_write) begin
            w_we = 1'b1;
            w_wd = w_sat;
        end else if (i_cmd.rd_zero) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_wa] <= w_wd;
        end
        if (i_cmd.acc_start || i_cmd.rd_start) begin
            r_store_q <= r_store[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_coef) begin
            r_table[w_tidx] <= w_coef;
        end
        if (i_cmd.acc_start) begin
            r_coef_q <= r_table[w_tidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_start || i_cmd.rd_start) begin
            r_addr   <= w_raddr;
            r_sample <= $signed(w_sample);
            r_last   <= i_in_last;
        end
        if (i_cmd.mult) begin
            r_prod <= r_sample * $signed({1'b0, r_coef_q});
        end
        if (i_cmd.out_load) begin
            r_out_value <= r_store_q;
            r_out_last  <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_hop       <= PW'(mod_small(HOP_W'(HOP_RESET), RING));
            r_wpos      <= '0;
            r_rpos      <= '0;
            r_primed    <= 1'b0;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ENABLE) begin
                    r_enable <= i_cfg_data[0];
                end else if (i_cfg_index == CFG_HOP) begin
                    r_hop <= PW'(mod_small(i_cfg_data, RING));
                end
            end
            if (i_cmd.clear_start) begin
                r_wpos  <= '0;
                r_rpos  <= '0;
                r_sweep <= '0;
            end else begin
                if (i_cmd.sweep) begin
                    r_sweep <= r_sweep + 1'b1;
                end
                if (i_cmd.acc_start && i_in_last) begin
                    r_wpos <= ring_add(r_wpos, r_hop);
                end
                if (i_cmd.rd_start && i_in_last) begin
                    r_rpos <= ring_add(r_rpos, r_hop);
                end
            end
            if (i_cmd.acc_start) begin
                r_primed <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.func       = t_func'(i_in_user);
    assign o_stat.enable     = r_enable;
    assign o_stat.primed     = r_primed;
    assign o_stat.sweep_last = (r_sweep == LAST_A);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_value;
    assign o_out_last  = r_out_last;

    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken item");

    a_rd_primed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_start |-> (r_primed && r_enable))
        else $error("read started before any accumulate");

    a_acc_primes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.acc_start |=> r_primed)
        else $error("accumulate did not set primed");

    a_clear_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_start |=> (r_wpos == '0 && r_rpos == '0 && r_sweep == '0))
        else $error("clear left a position or sweep count");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sweep |-> !(i_cmd.acc_write || i_cmd.rd_zero || i_cmd.acc_start))
        else $error("store written during clearing sweep");

endmodule

`default_nettype wire

>>> sv/overlap_add_accumulator.sv
// overlap-add accumulator top level: controller and datapath
// load and disabled or unprimed items are handled in the idle state; accumulate steps
// through store read, multiply, saturating write back on one store port
// read: store fetch, then output register load, waiting while an untaken result holds it
// clear, and reset: a sweep over CHANNELS*2*FRAME_LEN store entries, one store entry a cycle
// reset is synchronous active low; no item is taken until the sweep is done
`timescale 1ns / 1ps
`default_nettype none

module overlap_add_accumulator
    import oaa_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF,
    parameter int CHANNELS  = CHANNELS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // channel[0], index[9:1], sample[25:10], coefficient[41:26], zeros above
    input  wire logic [IN_W-1:0]   s_axis_tdata,
    // func[1:0]
    input  wire logic [FUNC_W-1:0] s_axis_tuser,
    // frame_end
    input  wire logic              s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // value[31:0]
    output logic [VAL_W-1:0]       m_axis_tdata,
    // step_last
    output logic                   m_axis_tlast,
    input  wire logic              i_cfg_we,
    input  wire logic [CFGI_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    oaa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (w_stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    oaa_datapath #(
        .FRAME_LEN (FRAME_LEN),
        .CHANNELS  (CHANNELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_in_last   (s_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> tb/tb_overlap_add_accumulator.sv
// self-checking testbench for the overlap-add accumulator: random stream stimulus against a predictor
`timescale 1ns / 1ps

module tb_overlap_add_accumulator;
    import oaa_pkg::*;

    localparam int RING_LEN      = 2 * FRAME_LEN_DEF;
    localparam int SWEEP_CYCLES  = CHANNELS_DEF * RING_LEN + 64;
    localparam int LONG_HOLD     = 400;
    localparam int SAT_RUN       = 16;
    localparam longint LIMIT_NS  = 64'd40_000_000;
    localparam longint SAT_HI    = 64'sd2147483647;
    localparam longint SAT_LO    = -64'sd2147483648;

    typedef struct {
        t_func                    func;
        bit                       chan;
        logic [IDX_W-1:0]         idx;
        logic signed [SMP_W-1:0]  smp;
        logic [COEF_W-1:0]        coef;
        bit                       fend;
        bit                       drain;
    } ola_op_t;

    typedef struct {
        logic [VAL_W-1:0] value;
        bit               last;
    } ola_readout_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic [FUNC_W-1:0] s_axis_tuser = FUNC_LOAD;
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [VAL_W-1:0]  m_axis_tdata;
    logic              m_axis_tlast;
    logic              i_cfg_we = 1'b0;
    logic [CFGI_W-1:0] i_cfg_index = CFG_ENABLE;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    // predictor state
    logic signed [VAL_W-1:0] ring_acc [CHANNELS_DEF][RING_LEN];
    logic [COEF_W-1:0]       win_coef [FRAME_LEN_DEF];
    logic [HOP_W-1:0]        wr_pos = '0;
    logic [HOP_W-1:0]        rd_pos = '0;
    bit                      primed = 1'b0;
    bit                      cfg_en = 1'b0;
    logic [HOP_W-1:0]        cfg_hop = HOP_W'(HOP_RESET);

    ola_op_t      op_q [$];
    ola_readout_t readout_q [$];
    ola_op_t      cur_op;
    bit           coef_known [FRAME_LEN_DEF];
    int           coef_known_idx [$];

    int ops_offered = 0;
    int ops_taken = 0;
    int reads_seen = 0;
    int mismatches = 0;
    int src_gap = 0;
    int src_quiet = 0;
    int sink_gap = 0;
    int sink_quiet = 0;
    bit long_hold_done = 1'b0;

    overlap_add_accumulator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int draw_gap(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 199);
        if (r == 0) begin
            quiet = $urandom_range(40, 150);
        end
        if (r < 110) return 0;
        if (r < 185) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SMP_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return SMP_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'h8000;
            2: return 16'hFFFF;
            3, 4, 5: return COEF_W'($urandom_range(0, 32768));
            default: return COEF_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic overlap_add_step(input ola_op_t op, output bit makes_out,
                                    output ola_readout_t res);
        logic [HOP_W-1:0] addr;
        longint prod;
        longint total;
        makes_out = 1'b0;
        res.value = '0;
        res.last = 1'b0;
        case (op.func)
            FUNC_LOAD: begin
                win_coef[op.idx] = op.coef;
            end
            FUNC_CLEAR: begin
                foreach (ring_acc[c, a]) ring_acc[c][a] = '0;
                wr_pos = '0;
                rd_pos = '0;
            end
            FUNC_ACC: begin
                if (cfg_en) begin
                    addr = wr_pos + op.idx;
                    prod = (longint'(op.smp) * longint'(win_coef[op.idx])) >>> 15;
                    total = longint'(ring_acc[op.chan][addr]) + prod;
                    if (total > SAT_HI) total = SAT_HI;
                    if (total < SAT_LO) total = SAT_LO;
                    ring_acc[op.chan][addr] = total[VAL_W-1:0];
                    primed = 1'b1;
                    if (op.fend) wr_pos = wr_pos + cfg_hop;
                end
            end
            FUNC_READ: begin
                if (cfg_en && primed) begin
                    addr = rd_pos + op.idx;
                    res.value = ring_acc[op.chan][addr];
                    res.last = op.fend;
                    ring_acc[op.chan][addr] = '0;
                    if (op.fend) rd_pos = rd_pos + cfg_hop;
                    makes_out = 1'b1;
                end
            end
            default: begin
                makes_out = 1'b0;
            end
        endcase
    endtask

    task automatic note_error(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && !(s_axis_tvalid && ops_taken != ops_offered)) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (op_q.size() != 0 && !(op_q[0].drain && readout_q.size() != 0)) begin
                cur_op = op_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= IN_W'({cur_op.coef, cur_op.smp, cur_op.idx, cur_op.chan});
                s_axis_tuser  <= cur_op.func;
                s_axis_tlast  <= cur_op.fend;
                ops_offered++;
                src_gap = draw_gap(src_quiet);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold once results are flowing
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!long_hold_done && reads_seen >= 30) begin
                long_hold_done = 1'b1;
                sink_gap = LONG_HOLD;
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                sink_gap = draw_gap(sink_quiet);
            end
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        ola_readout_t want;
        bit makes_out;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                ops_taken++;
                overlap_add_step(cur_op, makes_out, want);
                if (makes_out) readout_q.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                reads_seen++;
                if (readout_q.size() == 0) begin
                    note_error($sformatf("unexpected item value %0d last %0b",
                                         $signed(m_axis_tdata), m_axis_tlast));
                end else begin
                    want = readout_q.pop_front();
                    if (m_axis_tdata !== want.value || m_axis_tlast !== want.last) begin
                        note_error($sformatf("value exp %0d got %0d, last exp %0b got %0b",
                                             $signed(want.value), $signed(m_axis_tdata),
                                             want.last, m_axis_tlast));
                    end
                end
            end
        end
    end

    task automatic push_op(input t_func func, input bit chan, input int idx,
                           input logic [SMP_W-1:0] smp, input logic [COEF_W-1:0] coef,
                           input bit fend, input bit drain);
        ola_op_t op;
        op.func = func;
        op.chan = chan;
        op.idx = IDX_W'(idx);
        op.smp = smp;
        op.coef = coef;
        op.fend = fend;
        op.drain = drain;
        if (func == FUNC_LOAD && !coef_known[op.idx]) begin
            coef_known[op.idx] = 1'b1;
            coef_known_idx.push_back(int'(op.idx));
        end
        op_q.push_back(op);
    endtask

    task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == CFG_ENABLE) cfg_en = val[0];
        else cfg_hop = val[HOP_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait for the stream to drain, then for the slowest item (a clear sweep)
    task automatic settle();
        while (op_q.size() != 0 || ops_taken != ops_offered || readout_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SWEEP_CYCLES) @(posedge i_clk);
    endtask

    task automatic gen_random(input int n);
        int made;
        int len;
        int cut;
        int rlen;
        int k;
        int r;
        bit chan;
        bit first;
        made = 0;
        first = 1'b1;
        while (made < n) begin
            r = $urandom_range(0, 99);
            chan = 1'($urandom_range(0, 1));
            if (r < 45) begin
                // accumulate a short frame, then read back one step
                len = $urandom_range(1, 16);
                cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 16) : len - 1;
                for (k = 0; k < len; k++) begin
                    push_op(FUNC_ACC, chan, k, rand_sample(), COEF_W'($urandom_range(0, 65535)),
                            k == cut, 1'b0);
                end
                rlen = $urandom_range(1, len);
                for (k = 0; k < rlen; k++) begin
                    push_op(FUNC_READ, chan, k, rand_sample(), COEF_W'($urandom_range(0, 65535)),
                            k == rlen - 1, k == 0 && (first || $urandom_range(0, 29) == 0));
                end
                first = 1'b0;
                made += len + rlen;
            end else if (r < 60) begin
                push_op(FUNC_LOAD, chan, $urandom_range(0, 511), rand_sample(), rand_coef(),
                        1'($urandom_range(0, 1)), 1'b0);
                made++;
            end else if (r < 80) begin
                push_op(FUNC_ACC, chan,
                        coef_known_idx[$urandom_range(0, coef_known_idx.size() - 1)],
                        rand_sample(), COEF_W'($urandom_range(0, 65535)),
                        $urandom_range(0, 3) == 0, 1'b0);
                made++;
            end else if (r < 98) begin
                push_op(FUNC_READ, chan, $urandom_range(0, 511), rand_sample(),
                        COEF_W'($urandom_range(0, 65535)), $urandom_range(0, 3) == 0, 1'b0);
                made++;
            end else begin
                push_op(FUNC_CLEAR, chan, $urandom_range(0, 511), rand_sample(),
                        COEF_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), 1'b0);
                made++;
            end
        end
    endtask

    initial begin
        int k;
        foreach (ring_acc[c, a]) ring_acc[c][a] = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SWEEP_CYCLES) @(posedge i_clk);

        // disabled after reset: load and clear act, accumulate and read are ignored
        push_op(FUNC_LOAD, 0, 0, 16'h0000, 16'h0000, 0, 0);
        push_op(FUNC_LOAD, 0, 511, 16'h0000, 16'hFFFF, 0, 0);
        push_op(FUNC_LOAD, 0, 1, 16'h0000, 16'h8000, 0, 0);
        push_op(FUNC_LOAD, 0, 2, 16'h0000, 16'h0001, 0, 0);
        push_op(FUNC_LOAD, 0, 3, 16'h0000, 16'h7FFF, 0, 0);
        push_op(FUNC_ACC, 0, 1, 16'd100, 16'h0000, 1, 0);
        push_op(FUNC_READ, 0, 1, 16'h0000, 16'h0000, 1, 0);
        push_op(FUNC_CLEAR, 0, 0, 16'h0000, 16'h0000, 0, 0);
        settle();

        write_reg(CFG_ENABLE, {(CFG_W-1)'($urandom_range(0, 511)), 1'b1});
        write_reg(CFG_HOP, CFG_W'(512));
        // read before anything accumulated
        push_op(FUNC_READ, 1, 0, 16'h0000, 16'h0000, 0, 0);
        push_op(FUNC_ACC, 0, 1, 16'h8000, 16'h0000, 0, 0);
        push_op(FUNC_ACC, 0, 1, 16'h7FFF, 16'h0000, 0, 0);
        // floor rounding of negative products
        push_op(FUNC_ACC, 1, 2, 16'hFFFF, 16'h0000, 0, 0);
        push_op(FUNC_ACC, 1, 2, 16'h0001, 16'h0000, 0, 0);
        push_op(FUNC_ACC, 0, 511, 16'h7FFF, 16'h0000, 1, 0);
        push_op(FUNC_ACC, 0, 0, 16'h8000, 16'h0000, 0, 0);
        push_op(FUNC_READ, 0, 1, 16'h0000, 16'h0000, 0, 0);
        push_op(FUNC_READ, 0, 1, 16'h0000, 16'h0000, 0, 0);
        push_op(FUNC_READ, 1, 2, 16'h0000, 16'h0000, 0, 0);
        push_op(FUNC_READ, 0, 511, 16'h0000, 16'h0000, 1, 0);
        push_op(FUNC_READ, 0, 511, 16'h0000, 16'h0000, 0, 0);
        // clear keeps the primed state
        push_op(FUNC_CLEAR, 1, 5, 16'hFFFF, 16'hFFFF, 1, 0);
        push_op(FUNC_READ, 0, 0, 16'h0000, 16'h0000, 0, 0);
        push_op(FUNC_ACC, 1, 3, 16'h7FFF, 16'h0000, 1, 0);
        push_op(FUNC_READ, 1, 3, 16'h0000, 16'h0000, 1, 0);
        settle();

        write_reg(CFG_HOP, CFG_W'(1));
        for (k = 0; k < 16; k++) begin
            push_op(FUNC_LOAD, 1'($urandom_range(0, 1)), k, rand_sample(), rand_coef(), 0, 0);
        end
        gen_random(120);
        settle();

        write_reg(CFG_HOP, CFG_W'(0));
        gen_random(120);
        settle();

        write_reg(CFG_HOP, CFG_W'(1023));
        gen_random(120);
        settle();

        write_reg(CFG_ENABLE, CFG_W'(0));
        write_reg(CFG_HOP, CFG_W'($urandom_range(1, 512)));
        gen_random(40);
        settle();

        write_reg(CFG_ENABLE, CFG_W'(1));
        write_reg(CFG_HOP, CFG_W'(256));
        gen_random(120);
        settle();

        write_reg(CFG_HOP, CFG_W'($urandom_range(1, 512)));
        gen_random(120);
        settle();

        // full-scale products into one entry per channel, negative and positive
        write_reg(CFG_HOP, CFG_W'(512));
        push_op(FUNC_CLEAR, 0, 0, 16'h0000, 16'h0000, 0, 0);
        push_op(FUNC_LOAD, 0, 7, 16'h0000, 16'hFFFF, 0, 0);
        for (k = 0; k < SAT_RUN; k++) begin
            push_op(FUNC_ACC, 0, 7, 16'h8000, 16'h0000, 0, 0);
        end
        for (k = 0; k < SAT_RUN; k++) begin
            push_op(FUNC_ACC, 1, 7, 16'h7FFF, 16'h0000, 0, 0);
        end
        push_op(FUNC_READ, 0, 7, 16'h0000, 16'h0000, 0, 0);
        push_op(FUNC_READ, 1, 7, 16'h0000, 16'h0000, 1, 0);
        settle();

        if (mismatches == 0 && readout_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule
